// ===== src/swmc_pkg.sv =====
`default_nettype none

package swmc_pkg;

	// Default sizing
	localparam int WINDOW_MAX_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 32;

	// Fixed field widths of the channels and the window size register
	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 32;
	localparam int COST_W   = 40;
	localparam int SUM_W    = 40;
	localparam int WSIZE_W  = 9;

	// Operation applied to every cell of a sorted chain at once
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_CLEAR,
		OP_INS,
		OP_DEL,
		OP_PUSH,
		OP_POP,
		OP_DEL_PUSH,
		OP_INS_POP
	} chain_op_t;

	// Sequencer states of the top level
	typedef enum logic [1:0] {
		S_IDLE,
		S_RM,
		S_INS
	} state_t;

	// Channel payloads
	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                restart;
	} feed_item_t;

	typedef struct packed {
		logic [COST_W-1:0]   cost;
		logic [MEDIAN_W-1:0] median;
	} result_item_t;

endpackage

`default_nettype wire

// ===== src/swmc_stream_if.sv =====
`default_nettype none

// Valid/ready stream; a transfer happens when valid and ready are both high
interface swmc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/swmc_cell.sv =====
`default_nettype none

// One slot of a sorted chain. Neighbors are ordered front to back; "ahead"
// means this slot holds a value that strictly precedes the key.
module swmc_cell import swmc_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter bit DESCEND     = 1'b0,
	parameter bit FIRST       = 1'b0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire chain_op_t              op,
	input  wire logic [SAMPLE_BITS-1:0] key,
	input  wire logic [SAMPLE_BITS-1:0] left_val,
	input  wire logic                   left_vld,
	input  wire logic                   left_ahead,
	input  wire logic [SAMPLE_BITS-1:0] right_val,
	input  wire logic                   right_vld,
	input  wire logic                   right_ahead,
	output logic [SAMPLE_BITS-1:0]      val,
	output logic                        vld,
	output logic                        ahead
);

	logic [SAMPLE_BITS-1:0] val_q, nval;
	logic                   vld_q, nvld;

	// Order compare against the key
	always_comb begin
		if (DESCEND)
			ahead = vld_q && (val_q > key);
		else
			ahead = vld_q && (val_q < key);
	end

	// Local move decision
	always_comb begin
		nval = val_q;
		nvld = vld_q;
		case (op)
			OP_HOLD: begin
			end
			OP_CLEAR: begin
				nvld = 1'b0;
			end
			OP_PUSH: begin
				nval = left_val;
				nvld = left_vld;
			end
			OP_POP: begin
				nval = right_val;
				nvld = right_vld;
			end
			OP_INS: begin
				if (!ahead) begin
					if (FIRST || left_ahead) begin
						nval = key;
						nvld = 1'b1;
					end else begin
						nval = left_val;
						nvld = left_vld;
					end
				end
			end
			OP_DEL: begin
				if (!ahead) begin
					nval = right_val;
					nvld = right_vld;
				end
			end
			OP_DEL_PUSH: begin
				// slots up to the removed one move back, head takes the pushed value
				if (FIRST || left_ahead) begin
					nval = left_val;
					nvld = left_vld;
				end
			end
			OP_INS_POP: begin
				// slots before the insert point move forward, key lands just before it
				if (right_ahead) begin
					nval = right_val;
					nvld = right_vld;
				end else if (ahead) begin
					nval = key;
					nvld = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= 1'b0;
		else
			vld_q <= nvld;
	end

	always_ff @(posedge clk) begin
		val_q <= nval;
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

`default_nettype wire

// ===== src/swmc_chain.sv =====
`default_nettype none

// Row of sorted cells; the front cell holds the extreme value of the row
module swmc_chain import swmc_pkg::*; #(
	parameter int DEPTH       = WINDOW_MAX_DEF / 2,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter bit DESCEND     = 1'b0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire chain_op_t              op,
	input  wire logic [SAMPLE_BITS-1:0] key,
	input  wire logic [SAMPLE_BITS-1:0] push_val,
	output logic [SAMPLE_BITS-1:0]      front_val,
	output logic                        front_vld
);

	logic [SAMPLE_BITS-1:0] val [DEPTH];
	logic [DEPTH-1:0]       vld;
	logic [DEPTH-1:0]       ahead;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [SAMPLE_BITS-1:0] lv, rv;
		logic                   lvld, la, rvld, ra;

		// head sees the pushed value on its left
		if (i == 0) begin : g_head
			assign lv   = push_val;
			assign lvld = 1'b1;
			assign la   = 1'b0;
		end else begin : g_mid_l
			assign lv   = val[i-1];
			assign lvld = vld[i-1];
			assign la   = ahead[i-1];
		end

		// tail sees an empty slot on its right
		if (i == DEPTH - 1) begin : g_tail
			assign rv   = '0;
			assign rvld = 1'b0;
			assign ra   = 1'b0;
		end else begin : g_mid_r
			assign rv   = val[i+1];
			assign rvld = vld[i+1];
			assign ra   = ahead[i+1];
		end

		swmc_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.DESCEND     (DESCEND),
			.FIRST       (1'(i == 0))
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.key         (key),
			.left_val    (lv),
			.left_vld    (lvld),
			.left_ahead  (la),
			.right_val   (rv),
			.right_vld   (rvld),
			.right_ahead (ra),
			.val         (val[i]),
			.vld         (vld[i]),
			.ahead       (ahead[i])
		);
	end

	assign front_val = val[0];
	assign front_vld = vld[0];

endmodule

`default_nettype wire

// ===== src/sliding_window_median_cost.sv =====
`default_nettype none

// Running lower median and absolute-deviation cost over a sliding window.
// feed: one sample per transfer; restart set empties the window first.
// result: one transfer per item once the window holds window_size samples,
//   carrying the lower median and the sum of |sample - median| (40 bits).
// cfg_wen/cfg_wdata: writes window_size (0 reads as 1, above WINDOW_MAX
//   saturates) and empties the window; write only while the block is idle.
// The window lives in two cell rows: the lower half in descending order
// (front = median) and the upper half ascending. Each item takes one remove
// step and then one insert step; the next sample can be taken in the insert
// step. A result goes pending after the insert step, then to the output
// register. The oldest sample comes from an arrival ring memory.
// Reset: window empty, window_size 1, no result pending.
// Receiver stall: one result waits in the output register, one more waits
// behind it; the block then holds before its next remove step and drops
// feed.ready until the output register frees.
module sliding_window_median_cost import swmc_pkg::*; #(
	parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic [WSIZE_W-1:0] cfg_wdata,
	swmc_stream_if.sink             feed,
	swmc_stream_if.source           result
);

	localparam int CNT_W    = $clog2(WINDOW_MAX + 1);
	localparam int PTR_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int AW       = CNT_W + 1;
	localparam int CMP_W    = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;
	localparam int LO_DEPTH = (WINDOW_MAX + 1) / 2;
	localparam int UP_DEPTH = (WINDOW_MAX > 1) ? WINDOW_MAX / 2 : 1;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       win_q, fill_q, n_q;
	logic [CNT_W-1:0]       win_new, fill_new;
	logic [PTR_W-1:0]       rp_q, rp_eff, rp_next, old_addr;
	logic [AW-1:0]          old_sum;
	logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
	logic [SAMPLE_BITS-1:0] ring_rd_q, s_q, s_in, key;
	logic                   restart_q, rm_q, emit_q, res_pend_q;
	logic                   restart_in, full, emit;
	logic                   feed_xfer, feed_rdy, res_load, hold, rm_go, ins_go;
	logic [SUM_W-1:0]       lsum_q, tsum_q, l_add, l_sub;
	logic [SUM_W-1:0]       v_sum, s_sum, lo_sum, up_sum, cost_calc;
	logic                   out_vld_q;
	logic [COST_W-1:0]      cost_q;
	logic [MEDIAN_W-1:0]    median_q;
	chain_op_t              lo_op, up_op;
	logic [SAMPLE_BITS-1:0] lo_front, up_front;
	logic                   lo_vld, up_vld;

	// Feed side
	assign s_in       = SAMPLE_BITS'(feed.data.sample);
	assign restart_in = feed.data.restart;
	assign feed_xfer  = feed.valid && feed_rdy;
	assign feed.ready = feed_rdy;

	// Output register handoff
	assign res_load = res_pend_q && (!out_vld_q || result.ready);
	assign hold     = res_pend_q && !res_load;

	// Window size decode
	always_comb begin
		if (cfg_wdata == '0)
			win_new = CNT_W'(1);
		else if (CMP_W'(cfg_wdata) > CMP_W'(WINDOW_MAX))
			win_new = CNT_W'(WINDOW_MAX);
		else
			win_new = CNT_W'(cfg_wdata);
	end

	// Ring bookkeeping for the incoming item
	assign full     = !restart_in && (fill_q >= win_q);
	assign fill_new = restart_in ? CNT_W'(1) : (full ? fill_q : fill_q + CNT_W'(1));
	assign emit     = (fill_new == win_q);
	assign rp_eff   = restart_in ? '0 : rp_q;
	assign rp_next  = (rp_eff == PTR_W'(WINDOW_MAX - 1)) ? '0 : rp_eff + PTR_W'(1);

	// oldest slot = (rp - window) mod WINDOW_MAX
	assign old_sum  = AW'(rp_q) + AW'(WINDOW_MAX) - AW'(win_q);
	assign old_addr = (old_sum >= AW'(WINDOW_MAX)) ? PTR_W'(old_sum - AW'(WINDOW_MAX))
	                                               : PTR_W'(old_sum);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (feed_xfer)
					state_d = S_RM;
			end
			S_RM: begin
				if (!hold)
					state_d = S_INS;
			end
			S_INS: begin
				state_d = feed_xfer ? S_RM : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		feed_rdy = 1'b0;
		rm_go    = 1'b0;
		ins_go   = 1'b0;
		case (state_q)
			S_IDLE: feed_rdy = !hold;
			S_RM:   rm_go    = !hold;
			S_INS: begin
				feed_rdy = !hold;
				ins_go   = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sum operands
	assign v_sum  = SUM_W'(ring_rd_q);
	assign s_sum  = SUM_W'(s_q);
	assign lo_sum = SUM_W'(lo_front);
	assign up_sum = SUM_W'(up_front);
	assign key    = (state_q == S_RM) ? ring_rd_q : s_q;

	// Row operations and lower-sum delta; keeps lower size at ceil(n/2)
	always_comb begin
		lo_op = OP_HOLD;
		up_op = OP_HOLD;
		l_add = '0;
		l_sub = '0;
		if (cfg_wen) begin
			lo_op = OP_CLEAR;
			up_op = OP_CLEAR;
		end else if (rm_go) begin
			if (restart_q) begin
				lo_op = OP_CLEAR;
				up_op = OP_CLEAR;
			end else if (rm_q) begin
				if (n_q[0]) begin
					// odd count: lower half shrinks
					if (ring_rd_q <= lo_front) begin
						lo_op = OP_DEL;
						l_sub = v_sum;
					end else begin
						up_op = OP_DEL_PUSH;
						lo_op = OP_POP;
						l_sub = lo_sum;
					end
				end else begin
					// even count: upper half shrinks
					if (ring_rd_q > lo_front) begin
						up_op = OP_DEL;
					end else begin
						lo_op = OP_DEL_PUSH;
						up_op = OP_POP;
						l_add = up_sum;
						l_sub = v_sum;
					end
				end
			end
		end else if (ins_go) begin
			if (!n_q[0]) begin
				// even count: lower half grows
				if (!up_vld || s_q <= up_front) begin
					lo_op = OP_INS;
					l_add = s_sum;
				end else begin
					up_op = OP_INS_POP;
					lo_op = OP_PUSH;
					l_add = up_sum;
				end
			end else begin
				// odd count: upper half grows
				if (s_q >= lo_front) begin
					up_op = OP_INS;
				end else begin
					lo_op = OP_INS_POP;
					up_op = OP_PUSH;
					l_add = s_sum;
					l_sub = lo_sum;
				end
			end
		end
	end

	swmc_chain #(
		.DEPTH       (LO_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DESCEND     (1'b1)
	) u_lower (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (lo_op),
		.key       (key),
		.push_val  (up_front),
		.front_val (lo_front),
		.front_vld (lo_vld)
	);

	swmc_chain #(
		.DEPTH       (UP_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.DESCEND     (1'b0)
	) u_upper (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (up_op),
		.key       (key),
		.push_val  (lo_front),
		.front_val (up_front),
		.front_vld (up_vld)
	);

	// cost = total - 2*lower + median when the count is odd
	assign cost_calc = tsum_q - {lsum_q[SUM_W-2:0], 1'b0} + (n_q[0] ? lo_sum : '0);

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Window size and ring accounting
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q     <= CNT_W'(1);
			fill_q    <= '0;
			rp_q      <= '0;
			restart_q <= 1'b0;
			rm_q      <= 1'b0;
			emit_q    <= 1'b0;
		end else if (cfg_wen) begin
			win_q  <= win_new;
			fill_q <= '0;
			rp_q   <= '0;
		end else if (feed_xfer) begin
			fill_q    <= fill_new;
			rp_q      <= rp_next;
			restart_q <= restart_in;
			rm_q      <= full;
			emit_q    <= emit;
		end
	end

	// Arrival ring: write new sample, read the oldest (old data on collision)
	always_ff @(posedge clk) begin
		if (feed_xfer) begin
			s_q                <= s_in;
			ring_mem[rp_eff]   <= s_in;
			ring_rd_q          <= ring_mem[old_addr];
		end
	end

	// Row count and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			lsum_q <= '0;
			tsum_q <= '0;
		end else if (cfg_wen || (rm_go && restart_q)) begin
			n_q    <= '0;
			lsum_q <= '0;
			tsum_q <= '0;
		end else if (rm_go && rm_q) begin
			n_q    <= n_q - CNT_W'(1);
			lsum_q <= lsum_q + l_add - l_sub;
			tsum_q <= tsum_q - v_sum;
		end else if (ins_go) begin
			n_q    <= n_q + CNT_W'(1);
			lsum_q <= lsum_q + l_add - l_sub;
			tsum_q <= tsum_q + s_sum;
		end
	end

	// Pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_pend_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (ins_go)
				res_pend_q <= emit_q;
			else if (res_load)
				res_pend_q <= 1'b0;

			if (res_load)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			cost_q   <= COST_W'(cost_calc);
			median_q <= MEDIAN_W'(lo_front);
		end
	end

	assign result.valid       = out_vld_q;
	assign result.data.cost   = cost_q;
	assign result.data.median = median_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= win_q)
		else $error("fill count above window size");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> n_q == fill_q)
		else $error("row count disagrees with ring fill when idle");

	a_lower_front: assert property (@(posedge clk) disable iff (!arst_n)
		n_q != '0 |-> lo_vld)
		else $error("lower row empty with samples in window");

	a_upper_front: assert property (@(posedge clk) disable iff (!arst_n)
		n_q > CNT_W'(1) |-> up_vld)
		else $error("upper row empty with two or more samples");

	a_split_order: assert property (@(posedge clk) disable iff (!arst_n)
		lo_vld && up_vld |-> lo_front <= up_front)
		else $error("median above upper row front");

	a_ins_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS |-> !res_pend_q)
		else $error("previous result still pending during insert");

endmodule

`default_nettype wire
